/* hw/rtl/rcspd_pkg.sv */
package rcspd_pkg;

  localparam int NUM_CHANNELS  = 6;
  localparam int NUM_SLEW_REGS = 6;

  localparam int CH_W       = 3;
  localparam int WIDTH_W    = 12;
  localparam int TIME_W     = 32;
  localparam int SLEW_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NOSYNC = CFG_IDX_W'(NUM_SLEW_REGS);

  localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 12'd750;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 12'd2250;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd1500;

  localparam logic [TIME_W-1:0] BAD_HOLD_US     = 32'd500000;
  localparam logic [TIME_W-1:0] EDGE_TIMEOUT_US = 32'd200000;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic               age_ok;
    logic               bad;
  } lane_stat_t;

  function automatic logic width_in_range(input logic [WIDTH_W-1:0] w);
    return (w >= WIDTH_MIN) && (w <= WIDTH_MAX);
  endfunction

endpackage

/* hw/rtl/rcspd_lane.sv */
module rcspd_lane
  import rcspd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              level,
  input  logic              level_prev,
  input  logic [TIME_W-1:0] now,
  input  logic              upd,
  input  logic [SLEW_W-1:0] slew,
  output lane_stat_t        stat
);

  logic [TIME_W-1:0]  rise_r;
  logic [WIDTH_W-1:0] pw_r, pw_nxt;
  logic [WIDTH_W-1:0] meas_r;
  logic               meas_ok_r;
  logic               fall_r;
  logic               age_ok_r;

  logic [TIME_W-1:0]  elapsed;
  logic               rise_e, fall_e, meas_ok, age_ok;
  logic [WIDTH_W:0]   diff;
  logic               diff_neg;
  logic [WIDTH_W-1:0] mag;

  assign elapsed = now - rise_r;
  assign rise_e  = level & ~level_prev;
  assign fall_e  = ~level & level_prev;
  assign meas_ok = (elapsed >= TIME_W'(WIDTH_MIN)) && (elapsed <= TIME_W'(WIDTH_MAX));
  assign age_ok  = rise_e | (elapsed < EDGE_TIMEOUT_US);

  // step toward the new measurement, limited by slew
  always_comb begin
    diff     = {1'b0, meas_r} - {1'b0, pw_r};
    diff_neg = diff[WIDTH_W];
    mag      = diff_neg ? WIDTH_W'(-diff) : diff[WIDTH_W-1:0];
    pw_nxt   = pw_r;
    if (fall_r && meas_ok_r) begin
      if ((slew == '0) || ({{(SLEW_W-WIDTH_W){1'b0}}, mag} <= slew)) begin
        pw_nxt = meas_r;
      end else if (diff_neg) begin
        pw_nxt = pw_r - slew[WIDTH_W-1:0];
      end else begin
        pw_nxt = pw_r + slew[WIDTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r    <= '0;
      pw_r      <= WIDTH_RESET;
      fall_r    <= 1'b0;
      meas_ok_r <= 1'b0;
      age_ok_r  <= 1'b0;
    end else begin
      if (load) begin
        if (rise_e) begin
          rise_r <= now;
        end
        fall_r    <= fall_e;
        meas_ok_r <= meas_ok;
        age_ok_r  <= age_ok;
      end
      if (upd) begin
        pw_r <= pw_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meas_r <= elapsed[WIDTH_W-1:0];
    end
  end

  assign stat.width  = pw_r;
  assign stat.age_ok = age_ok_r;
  assign stat.bad    = fall_r & ~meas_ok_r;

endmodule

/* hw/rtl/rcspd_merge.sv */
module rcspd_merge
  import rcspd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    upd,
  input  logic [TIME_W-1:0]       now,
  input  lane_stat_t              stat [NUM_CHANNELS],
  output logic [NUM_CHANNELS-1:0] ok
);

  logic [TIME_W-1:0]       bad_time_r;
  logic [NUM_CHANNELS-1:0] bad_vec;
  logic                    bad_clear;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      bad_vec[i] = stat[i].bad;
    end
  end

  assign bad_clear = (now - bad_time_r) > BAD_HOLD_US;

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ok[i] = bad_clear & stat[i].age_ok & width_in_range(stat[i].width);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_time_r <= '0;
    end else if (upd && (|bad_vec)) begin
      bad_time_r <= now;
    end
  end

endmodule

/* hw/rtl/rc_servo_pulse_decoder_unit.sv */
// Servo pulse-width decoder, one lane per channel.
// Input channel: in_valid/in_stall carries one beat per pin sample
// (in_pin_levels, in_time_us). Each sample yields NUM_CHANNELS output beats
// on out_valid/out_stall, channel 0 first, out_last on the final channel.
// Config: cfg_we writes cfg_wdata to register cfg_index (slew steps 0..5,
// then the no-sync width); indexes past the list are dropped.
// Pipeline: edge detect and timing in the lanes, then width update and
// bad-pulse merge, then a snapshot into a pending result buffer, then the
// output serializer, which shows the first output beat.
// The serializer sends one channel per cycle while out_stall is low; a
// new sample is taken while the previous one's beats are still going out,
// as long as the lane, merge and pending stages hold no other sample.
// Out_stall holds the current beat; the pending buffer fills and then
// in_stall rises. Reset clears the control and edge state (not the data
// buffers), widths go to 1500, no-sync to 1500, slews to unlimited; no beats are pending after reset.
module rc_servo_pulse_decoder_unit
  import rcspd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [NUM_CHANNELS-1:0] in_pin_levels,
  input  logic [TIME_W-1:0]       in_time_us,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [WIDTH_W-1:0]      out_width_out,
  output logic                    out_valid_res,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic [SLEW_W-1:0]       slew_r [NUM_SLEW_REGS];
  logic [WIDTH_W-1:0]      nosync_r;
  logic [NUM_CHANNELS-1:0] prev_levels_r;
  logic [TIME_W-1:0]       now_r;
  logic                    s1_v_r, s2_v_r;

  logic [WIDTH_W-1:0]      pend_width_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pend_ok_r;
  logic                    pend_v_r, pend_v_nxt;

  logic [WIDTH_W-1:0]      ser_width_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ser_ok_r;
  logic                    ser_v_r, ser_v_nxt;
  logic [CH_W-1:0]         ser_idx_r, ser_idx_nxt;

  logic                    in_take, out_take, ser_load;
  lane_stat_t              stat [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] ok;

  assign in_stall = s1_v_r | s2_v_r | pend_v_r;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLEW_REGS; i++) begin
        slew_r[i] <= '0;
      end
      nosync_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      if (cfg_index < REG_NOSYNC) begin
        slew_r[cfg_index] <= cfg_wdata;
      end else if (cfg_index == REG_NOSYNC) begin
        nosync_r <= cfg_wdata[WIDTH_W-1:0];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < NUM_CHANNELS; g++) begin : g_lane
      logic [SLEW_W-1:0] lane_slew;
      if (g < NUM_SLEW_REGS) begin : g_slew
        assign lane_slew = slew_r[g];
      end else begin : g_noslew
        assign lane_slew = '0;
      end
      rcspd_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_take),
        .level      (in_pin_levels[g]),
        .level_prev (prev_levels_r[g]),
        .now        (in_time_us),
        .upd        (s1_v_r),
        .slew       (lane_slew),
        .stat       (stat[g])
      );
    end
  endgenerate

  rcspd_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s1_v_r),
    .now   (now_r),
    .stat  (stat),
    .ok    (ok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
    end else begin
      if (in_take) begin
        prev_levels_r <= in_pin_levels;
      end
      s1_v_r <= in_take;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      now_r <= in_time_us;
    end
  end

  assign out_take = ser_v_r & ~out_stall;

  always_comb begin
    ser_load    = 1'b0;
    ser_v_nxt   = ser_v_r;
    ser_idx_nxt = ser_idx_r;
    pend_v_nxt  = pend_v_r;
    if (out_take) begin
      if (ser_idx_r == LAST_CH) begin
        ser_v_nxt = 1'b0;
      end else begin
        ser_idx_nxt = ser_idx_r + 1'b1;
      end
    end
    if (pend_v_r && (!ser_v_r || (out_take && (ser_idx_r == LAST_CH)))) begin
      ser_load    = 1'b1;
      ser_v_nxt   = 1'b1;
      ser_idx_nxt = '0;
      pend_v_nxt  = 1'b0;
    end
    if (s2_v_r) begin
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r  <= 1'b0;
      ser_v_r   <= 1'b0;
      ser_idx_r <= '0;
    end else begin
      pend_v_r  <= pend_v_nxt;
      ser_v_r   <= ser_v_nxt;
      ser_idx_r <= ser_idx_nxt;
    end
  end

  // snapshot after the width update; invalid channels get the no-sync width
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pend_width_r[i] <= ok[i] ? stat[i].width : nosync_r;
      end
      pend_ok_r <= ok;
    end
    if (ser_load) begin
      ser_width_r <= pend_width_r;
      ser_ok_r    <= pend_ok_r;
    end
  end

  assign out_valid     = ser_v_r;
  assign out_channel   = ser_idx_r;
  assign out_width_out = ser_width_r[ser_idx_r];
  assign out_valid_res = ser_ok_r[ser_idx_r];
  assign out_last      = (ser_idx_r == LAST_CH);

endmodule
